// File: sv/rsp_pkg.sv
// Shared types and constants for the typed record stream parser.
package rsp_pkg;

    localparam logic [14:0] MAX_BYTES_RESET = 15'(16 * 1024);
    localparam logic [7:0]  BLOB_VERSION    = 8'd1;
    localparam logic [7:0]  TYPE_STRING     = 8'd1;
    localparam logic [7:0]  TYPE_INT        = 8'd2;
    localparam logic [7:0]  TYPE_BOOL       = 8'd3;
    localparam logic [31:0] INT_BYTES       = 32'd8;

    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_STRING = 2'd1;
    localparam logic [1:0] KIND_INT    = 2'd2;
    localparam logic [1:0] KIND_BOOL   = 2'd3;

    localparam logic [3:0] ROLE_IGNORED = 4'd9;

    // Phase codes double as byte role codes.
    typedef enum logic [3:0] {
        PH_VERSION = 4'd0,
        PH_COUNT   = 4'd1,
        PH_KEYLEN  = 4'd2,
        PH_KEY     = 4'd3,
        PH_TYPE    = 4'd4,
        PH_STRLEN  = 4'd5,
        PH_STRBYTE = 4'd6,
        PH_INT     = 4'd7,
        PH_BOOL    = 4'd8,
        PH_DONE    = 4'd9
    } rsp_phase_t;

    typedef struct packed {
        logic [3:0]         byte_role;
        logic [15:0]        entry_index;
        logic               entry_done;
        logic [1:0]         value_kind;
        logic signed [63:0] int_value;
        logic               bool_value;
        logic               error_seen;
        logic               blob_accepted;
        logic               blob_end;
    } rsp_result_t;

endpackage

// File: sv/rsp_apb_regs.sv
// APB register block holding the maximum blob length.
module rsp_apb_regs (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [14:0] max_bytes
);
    import rsp_pkg::*;

    logic [14:0] max_bytes_reg;
    logic        hit;

    assign hit    = (paddr[2] == 1'b0);
    assign pready = 1'b1;
    assign prdata = hit ? {17'd0, max_bytes_reg} : 32'd0;
    assign max_bytes = max_bytes_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_bytes_reg <= MAX_BYTES_RESET;
        end
        else if (psel && penable && pwrite && pready && hit)
        begin
            max_bytes_reg <= pwdata[14:0];
        end
    end

endmodule

// File: sv/rsp_parser.sv
// Parse state registers and the combinational step logic for one blob byte.
module rsp_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  logic [7:0]           data_byte,
    input  logic                 last_byte,
    input  logic [14:0]          max_bytes,
    output rsp_pkg::rsp_result_t result
);
    import rsp_pkg::*;

    rsp_phase_t  phase_reg, phase_next, step_phase;
    logic [31:0] fbl_reg, fbl_next;
    logic [15:0] entries_reg, entries_next;
    logic [15:0] number_reg, number_next;
    logic [15:0] seen_reg, seen_next;
    logic [63:0] shift_reg, shift_next;
    logic        failed_reg, failed_next, step_failed;

    logic [15:0] seen_inc;
    logic        fail_pre;
    logic [63:0] shift_in;
    logic [31:0] fbl_dec;
    logic        fbl_zero;
    logic [15:0] ent_dec;

    assign seen_inc = (seen_reg != 16'hFFFF) ? seen_reg + 16'd1 : seen_reg;
    assign fail_pre = failed_reg || (seen_inc > {1'b0, max_bytes});
    assign shift_in = {shift_reg[55:0], data_byte};
    assign fbl_dec  = fbl_reg - 32'd1;
    assign fbl_zero = (fbl_dec == 32'd0);
    assign ent_dec  = entries_reg - 16'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_VERSION;
            fbl_reg     <= 32'd0;
            entries_reg <= 16'd0;
            number_reg  <= 16'd0;
            seen_reg    <= 16'd0;
            shift_reg   <= 64'd0;
            failed_reg  <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            fbl_reg     <= fbl_next;
            entries_reg <= entries_next;
            number_reg  <= number_next;
            seen_reg    <= seen_next;
            shift_reg   <= shift_next;
            failed_reg  <= failed_next;
        end
    end

    // Next state.
    always_comb
    begin
        phase_next   = phase_reg;
        fbl_next     = fbl_reg;
        entries_next = entries_reg;
        number_next  = number_reg;
        seen_next    = seen_reg;
        shift_next   = shift_reg;
        failed_next  = failed_reg;
        step_phase   = phase_reg;
        step_failed  = failed_reg;
        if (fire)
        begin
            seen_next   = seen_inc;
            failed_next = fail_pre;
            if (!fail_pre)
            begin
                case (phase_reg)
                    PH_VERSION:
                    begin
                        if (data_byte != BLOB_VERSION)
                        begin
                            failed_next = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_COUNT;
                            fbl_next   = 32'd2;
                            shift_next = 64'd0;
                        end
                    end
                    PH_COUNT:
                    begin
                        shift_next = shift_in;
                        fbl_next   = fbl_dec;
                        if (fbl_zero)
                        begin
                            entries_next = shift_in[15:0];
                            if (shift_in[15:0] == 16'd0)
                            begin
                                phase_next = PH_DONE;
                            end
                            else
                            begin
                                phase_next = PH_KEYLEN;
                                fbl_next   = 32'd2;
                                shift_next = 64'd0;
                            end
                        end
                    end
                    PH_KEYLEN:
                    begin
                        shift_next = shift_in;
                        fbl_next   = fbl_dec;
                        if (fbl_zero)
                        begin
                            phase_next = (shift_in[15:0] == 16'd0) ? PH_TYPE : PH_KEY;
                            fbl_next   = {16'd0, shift_in[15:0]};
                            shift_next = 64'd0;
                        end
                    end
                    PH_KEY:
                    begin
                        fbl_next = fbl_dec;
                        if (fbl_zero)
                        begin
                            phase_next = PH_TYPE;
                        end
                    end
                    PH_TYPE:
                    begin
                        shift_next = 64'd0;
                        if (data_byte == TYPE_STRING)
                        begin
                            phase_next = PH_STRLEN;
                            fbl_next   = 32'd4;
                        end
                        else if (data_byte == TYPE_INT)
                        begin
                            phase_next = PH_INT;
                            fbl_next   = INT_BYTES;
                        end
                        else if (data_byte == TYPE_BOOL)
                        begin
                            phase_next = PH_BOOL;
                            fbl_next   = 32'd1;
                        end
                        else
                        begin
                            shift_next  = shift_reg;
                            failed_next = 1'b1;
                        end
                    end
                    PH_STRLEN, PH_STRBYTE, PH_INT, PH_BOOL:
                    begin
                        if (phase_reg != PH_BOOL)
                        begin
                            fbl_next = fbl_dec;
                        end
                        if (phase_reg == PH_STRLEN || phase_reg == PH_INT)
                        begin
                            shift_next = shift_in;
                        end
                        if (phase_reg == PH_BOOL && data_byte > 8'd1)
                        begin
                            failed_next = 1'b1;
                        end
                        else if (phase_reg == PH_STRLEN && fbl_zero
                                 && shift_in[31:0] != 32'd0)
                        begin
                            phase_next = PH_STRBYTE;
                            fbl_next   = shift_in[31:0];
                            shift_next = 64'd0;
                        end
                        else if (phase_reg == PH_BOOL || fbl_zero)
                        begin
                            // The entry completes on this beat.
                            entries_next = ent_dec;
                            number_next  = number_reg + 16'd1;
                            if (ent_dec == 16'd0)
                            begin
                                phase_next = PH_DONE;
                            end
                            else
                            begin
                                phase_next = PH_KEYLEN;
                                fbl_next   = 32'd2;
                                shift_next = 64'd0;
                            end
                        end
                    end
                    default:
                    begin
                        failed_next = 1'b1;
                    end
                endcase
            end
            step_phase  = phase_next;
            step_failed = failed_next;
            if (last_byte)
            begin
                phase_next   = PH_VERSION;
                fbl_next     = 32'd0;
                entries_next = 16'd0;
                number_next  = 16'd0;
                seen_next    = 16'd0;
                shift_next   = 64'd0;
                failed_next  = 1'b0;
            end
        end
    end

    // Result of the current beat.
    always_comb
    begin
        result               = '0;
        result.byte_role     = ROLE_IGNORED;
        result.entry_index   = number_reg;
        result.blob_end      = last_byte;
        if (!fail_pre)
        begin
            case (phase_reg)
                PH_VERSION, PH_COUNT, PH_KEYLEN, PH_KEY, PH_TYPE:
                begin
                    result.byte_role = phase_reg;
                end
                PH_STRLEN:
                begin
                    result.byte_role = phase_reg;
                    if (fbl_zero && shift_in[31:0] == 32'd0)
                    begin
                        result.entry_done = 1'b1;
                        result.value_kind = KIND_STRING;
                    end
                end
                PH_STRBYTE:
                begin
                    result.byte_role = phase_reg;
                    if (fbl_zero)
                    begin
                        result.entry_done = 1'b1;
                        result.value_kind = KIND_STRING;
                    end
                end
                PH_INT:
                begin
                    result.byte_role = phase_reg;
                    if (fbl_zero)
                    begin
                        result.entry_done = 1'b1;
                        result.value_kind = KIND_INT;
                        result.int_value  = shift_in;
                    end
                end
                PH_BOOL:
                begin
                    result.byte_role = phase_reg;
                    if (data_byte <= 8'd1)
                    begin
                        result.entry_done = 1'b1;
                        result.value_kind = KIND_BOOL;
                        result.bool_value = data_byte[0];
                    end
                end
                default:
                begin
                    result.byte_role = ROLE_IGNORED;
                end
            endcase
        end
        result.error_seen    = step_failed || (last_byte && step_phase != PH_DONE);
        result.blob_accepted = last_byte && !result.error_seen;
    end

    // A last beat always leaves a fresh parse behind it.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && last_byte |=> phase_reg == PH_VERSION && !failed_reg && seen_reg == 16'd0)
        else $error("parse state not cleared after the last beat");

    // An error stays set until the blob ends.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && failed_reg && !last_byte |=> failed_reg)
        else $error("error flag dropped within a blob");

    // A failed parse leaves every later byte ignored and completes nothing.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && fail_pre |-> result.byte_role == ROLE_IGNORED && !result.entry_done)
        else $error("byte after an error was not ignored");

    // A completed entry always carries a kind, and only then.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> result.entry_done == (result.value_kind != KIND_NONE))
        else $error("entry completion and value kind disagree");

endmodule

// File: sv/rsp_result_reg.sv
// Result register between the parser and the output channel.
module rsp_result_reg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rsp_pkg::rsp_result_t in_result,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rsp_pkg::rsp_result_t out_result
);
    import rsp_pkg::*;

    logic        valid_reg;
    rsp_result_t data_reg;

    assign in_ready   = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_result = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= in_result;
        end
    end

endmodule

// File: sv/typed_record_stream_parser_core.sv
// Top level of the typed record stream parser.
// Takes one blob byte per clock cycle and returns one tagged result beat for
// every byte, in order. Each byte is parsed in the same cycle it is accepted by
// the phase, counter and shift logic of the parser, and the result lands in a
// single output register, so a result appears in the cycle after its byte and a
// new byte is accepted in every cycle that the output register is free or
// being emptied. The verdict of a blob comes with its last byte, after which
// the parse restarts; no clearing pass is needed after reset. The maximum blob
// length sits in an APB register at byte address 0.
module typed_record_stream_parser_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         data_byte,
    input  logic               last_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [3:0]         byte_role,
    output logic [15:0]        entry_index,
    output logic               entry_done,
    output logic [1:0]         value_kind,
    output logic signed [63:0] int_value,
    output logic               bool_value,
    output logic               error_seen,
    output logic               blob_accepted,
    output logic               blob_end,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import rsp_pkg::*;

    logic [14:0] max_bytes;
    logic        fire;
    rsp_result_t step_result;
    rsp_result_t out_result;

    assign fire = in_valid && in_ready;

    rsp_apb_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .max_bytes (max_bytes)
    );

    rsp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .max_bytes (max_bytes),
        .result    (step_result)
    );

    rsp_result_reg u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_result  (step_result),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_result (out_result)
    );

    assign byte_role     = out_result.byte_role;
    assign entry_index   = out_result.entry_index;
    assign entry_done    = out_result.entry_done;
    assign value_kind    = out_result.value_kind;
    assign int_value     = out_result.int_value;
    assign bool_value    = out_result.bool_value;
    assign error_seen    = out_result.error_seen;
    assign blob_accepted = out_result.blob_accepted;
    assign blob_end      = out_result.blob_end;

endmodule

// File: tb/typed_record_stream_parser_core_tb.sv
// Self-checking testbench for the typed record stream parser: directed and random blobs.
`timescale 1ns / 1ps

module typed_record_stream_parser_core_tb;
    import rsp_pkg::*;

    localparam int         REG_MAX_BLOB_BYTES = 0;
    localparam logic [2:0] ADDR_MAX_BLOB_BYTES = 3'(4 * REG_MAX_BLOB_BYTES);
    localparam int         LONG_HOLD_CYCLES = 300;
    localparam int         MAX_PRINTED = 40;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } beat_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [7:0]         data_byte = 8'h00;
    logic               last_byte = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [3:0]         byte_role;
    logic [15:0]        entry_index;
    logic               entry_done;
    logic [1:0]         value_kind;
    logic signed [63:0] int_value;
    logic               bool_value;
    logic               error_seen;
    logic               blob_accepted;
    logic               blob_end;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = 3'd0;
    logic [31:0]        pwdata = 32'd0;
    logic [31:0]        prdata;
    logic               pready;

    typed_record_stream_parser_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .last_byte     (last_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .byte_role     (byte_role),
        .entry_index   (entry_index),
        .entry_done    (entry_done),
        .value_kind    (value_kind),
        .int_value     (int_value),
        .bool_value    (bool_value),
        .error_seen    (error_seen),
        .blob_accepted (blob_accepted),
        .blob_end      (blob_end),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Parser shadow state, kept in step with every accepted byte.
    logic [14:0] max_bytes = MAX_BYTES_RESET;
    rsp_phase_t  parse_phase = PH_VERSION;
    logic [31:0] field_left = 32'd0;
    logic [15:0] entries_left = 16'd0;
    logic [15:0] entry_count = 16'd0;
    logic [15:0] bytes_seen = 16'd0;
    logic [63:0] shifter = 64'd0;
    logic        failed = 1'b0;

    rsp_result_t expected_tags[$];
    beat_t       byte_queue[$];
    logic [7:0]  blob[$];
    int          type_at[$];
    int          bool_at[$];

    int   tag_errors = 0;
    int   tags_checked = 0;
    int   send_gap = 0;
    int   ready_gap = 0;
    int   hold_left = 0;
    logic hold_armed = 1'b0;
    logic hold_used = 1'b0;
    logic quiet = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

    task automatic flag_mismatch(input string msg);
        tag_errors++;
        if (tag_errors <= MAX_PRINTED)
            $display("%0t: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            flag_mismatch($sformatf("beat %0d %s: got %0h, expected %0h",
                                    tags_checked, name, got, want));
    endtask

    task automatic clear_parse();
        parse_phase  = PH_VERSION;
        field_left   = 32'd0;
        entries_left = 16'd0;
        entry_count  = 16'd0;
        bytes_seen   = 16'd0;
        shifter      = 64'd0;
        failed       = 1'b0;
    endtask

    task automatic open_field(input rsp_phase_t ph, input logic [31:0] len);
        parse_phase = ph;
        field_left  = len;
        shifter     = 64'd0;
    endtask

    task automatic close_entry();
        entry_count  = entry_count + 16'd1;
        entries_left = entries_left - 16'd1;
        if (entries_left == 16'd0)
            parse_phase = PH_DONE;
        else
            open_field(PH_KEYLEN, 32'd2);
    endtask

    // Works out the tag beat that one accepted byte should produce.
    task automatic tag_byte(input logic [7:0] b, input logic last, output rsp_result_t r);
        r = '0;
        r.byte_role   = ROLE_IGNORED;
        r.entry_index = entry_count;
        r.blob_end    = last;
        if (bytes_seen != 16'hFFFF)
            bytes_seen = bytes_seen + 16'd1;
        if (!failed && bytes_seen > {1'b0, max_bytes})
            failed = 1'b1;
        if (!failed)
        begin
            case (parse_phase)
                PH_VERSION:
                begin
                    r.byte_role = PH_VERSION;
                    if (b != BLOB_VERSION)
                        failed = 1'b1;
                    else
                        open_field(PH_COUNT, 32'd2);
                end
                PH_COUNT:
                begin
                    r.byte_role = PH_COUNT;
                    shifter = {shifter[55:0], b};
                    field_left = field_left - 32'd1;
                    if (field_left == 32'd0)
                    begin
                        entries_left = shifter[15:0];
                        if (entries_left == 16'd0)
                            parse_phase = PH_DONE;
                        else
                            open_field(PH_KEYLEN, 32'd2);
                    end
                end
                PH_KEYLEN:
                begin
                    r.byte_role = PH_KEYLEN;
                    shifter = {shifter[55:0], b};
                    field_left = field_left - 32'd1;
                    if (field_left == 32'd0)
                        open_field(shifter[15:0] == 16'd0 ? PH_TYPE : PH_KEY,
                                   {16'd0, shifter[15:0]});
                end
                PH_KEY:
                begin
                    r.byte_role = PH_KEY;
                    field_left = field_left - 32'd1;
                    if (field_left == 32'd0)
                        parse_phase = PH_TYPE;
                end
                PH_TYPE:
                begin
                    r.byte_role = PH_TYPE;
                    if (b == TYPE_STRING)
                        open_field(PH_STRLEN, 32'd4);
                    else if (b == TYPE_INT)
                        open_field(PH_INT, INT_BYTES);
                    else if (b == TYPE_BOOL)
                        open_field(PH_BOOL, 32'd1);
                    else
                        failed = 1'b1;
                end
                PH_STRLEN:
                begin
                    r.byte_role = PH_STRLEN;
                    shifter = {shifter[55:0], b};
                    field_left = field_left - 32'd1;
                    if (field_left == 32'd0)
                    begin
                        if (shifter[31:0] == 32'd0)
                        begin
                            r.entry_done = 1'b1;
                            r.value_kind = KIND_STRING;
                            close_entry();
                        end
                        else
                        begin
                            open_field(PH_STRBYTE, shifter[31:0]);
                        end
                    end
                end
                PH_STRBYTE:
                begin
                    r.byte_role = PH_STRBYTE;
                    field_left = field_left - 32'd1;
                    if (field_left == 32'd0)
                    begin
                        r.entry_done = 1'b1;
                        r.value_kind = KIND_STRING;
                        close_entry();
                    end
                end
                PH_INT:
                begin
                    r.byte_role = PH_INT;
                    shifter = {shifter[55:0], b};
                    field_left = field_left - 32'd1;
                    if (field_left == 32'd0)
                    begin
                        r.entry_done = 1'b1;
                        r.value_kind = KIND_INT;
                        r.int_value  = shifter;
                        close_entry();
                    end
                end
                PH_BOOL:
                begin
                    r.byte_role = PH_BOOL;
                    if (b > 8'd1)
                    begin
                        failed = 1'b1;
                    end
                    else
                    begin
                        r.entry_done = 1'b1;
                        r.value_kind = KIND_BOOL;
                        r.bool_value = b[0];
                        close_entry();
                    end
                end
                default:
                    // A byte after the blob is complete is a trailing byte.
                    failed = 1'b1;
            endcase
        end
        if (last)
        begin
            if (!failed && parse_phase != PH_DONE)
                failed = 1'b1;
            r.blob_accepted = !failed;
        end
        r.error_seen = failed;
        if (last)
            clear_parse();
    endtask

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : byte_driver
        beat_t beat;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap = 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (byte_queue.size() != 0)
            begin
                beat = byte_queue.pop_front();
                data_byte <= beat.data;
                last_byte <= beat.last;
                in_valid  <= 1'b1;
                send_gap = pick_gap();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result side: short random gaps after beats, and one long hold-off when armed.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
                ready_gap = pick_gap();
            if (hold_armed && !hold_used)
            begin
                hold_used = 1'b1;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (ready_gap > 0)
            begin
                ready_gap--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Prediction and comparison share one process so that their order is fixed.
    always @(posedge clk)
    begin : tag_check
        rsp_result_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                tag_byte(data_byte, last_byte, want);
                expected_tags.push_back(want);
            end
            if (out_valid && out_ready)
            begin
                if (expected_tags.size() == 0)
                begin
                    flag_mismatch($sformatf("beat %0d arrived with nothing expected",
                                            tags_checked));
                end
                else
                begin
                    want = expected_tags.pop_front();
                    check_field("byte_role", byte_role, want.byte_role);
                    check_field("entry_index", entry_index, want.entry_index);
                    check_field("entry_done", entry_done, want.entry_done);
                    check_field("value_kind", value_kind, want.value_kind);
                    check_field("int_value", int_value, want.int_value);
                    check_field("bool_value", bool_value, want.bool_value);
                    check_field("error_seen", error_seen, want.error_seen);
                    check_field("blob_accepted", blob_accepted, want.blob_accepted);
                    check_field("blob_end", blob_end, want.blob_end);
                end
                tags_checked++;
            end
        end
    end

    task automatic queue_blob();
        beat_t beat;
        foreach (blob[i])
        begin
            beat.data = blob[i];
            beat.last = (i == blob.size() - 1);
            byte_queue.push_back(beat);
        end
    endtask

    task automatic send_hex(input string s);
        string pair;
        blob.delete();
        for (int i = 0; i + 1 < s.len(); i += 3)
        begin
            pair = s.substr(i, i + 1);
            blob.push_back(8'(pair.atohex()));
        end
        queue_blob();
    endtask

    // Builds a well-formed blob with random content, noting where type and bool bytes sit.
    task automatic build_blob();
        logic [15:0] count;
        logic [15:0] klen;
        logic [31:0] slen;
        logic [7:0]  kind;
        blob.delete();
        type_at.delete();
        bool_at.delete();
        count = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 4));
        blob.push_back(BLOB_VERSION);
        blob.push_back(count[15:8]);
        blob.push_back(count[7:0]);
        repeat (count)
        begin
            klen = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(256, 270))
                                                : 16'($urandom_range(0, 4));
            blob.push_back(klen[15:8]);
            blob.push_back(klen[7:0]);
            repeat (klen) blob.push_back(8'($urandom()));
            kind = 8'($urandom_range(1, 3));
            type_at.push_back(blob.size());
            blob.push_back(kind);
            case (kind)
                TYPE_STRING:
                begin
                    slen = ($urandom_range(0, 19) == 0) ? 32'($urandom_range(256, 300))
                                                        : 32'($urandom_range(0, 6));
                    for (int i = 3; i >= 0; i--)
                        blob.push_back(slen[8*i +: 8]);
                    repeat (slen) blob.push_back(8'($urandom()));
                end
                TYPE_INT:
                    repeat (8) blob.push_back(8'($urandom()));
                default:
                begin
                    bool_at.push_back(blob.size());
                    blob.push_back(8'($urandom_range(0, 1)));
                end
            endcase
        end
    endtask

    // Most blobs stay intact; the rest are broken in one of several ways.
    task automatic break_blob();
        int v;
        int keep;
        if ($urandom_range(0, 99) < 70)
            return;
        case ($urandom_range(0, 6))
            0:
            begin
                v = $urandom_range(0, 254);
                blob[0] = 8'(v >= 1 ? v + 1 : v);
            end
            1:
            begin
                if (type_at.size() != 0)
                begin
                    v = $urandom_range(0, 252);
                    blob[type_at[$urandom_range(0, type_at.size() - 1)]] =
                        8'(v >= 1 ? v + 3 : v);
                end
            end
            2:
            begin
                if (bool_at.size() != 0)
                    blob[bool_at[$urandom_range(0, bool_at.size() - 1)]] =
                        8'($urandom_range(2, 255));
            end
            3:
            begin
                if (blob.size() > 1)
                begin
                    keep = $urandom_range(1, blob.size() - 1);
                    while (blob.size() > keep)
                        void'(blob.pop_back());
                end
            end
            4:
                repeat ($urandom_range(1, 3)) blob.push_back(8'($urandom()));
            5:
                blob[$urandom_range(0, blob.size() - 1)] = 8'($urandom());
            default:
            begin
                blob.delete();
                repeat ($urandom_range(1, 12)) blob.push_back(8'($urandom()));
                if ($urandom_range(0, 1) == 1)
                    blob[0] = BLOB_VERSION;
            end
        endcase
    endtask

    task automatic random_blobs(input int byte_budget);
        int queued;
        queued = 0;
        while (queued < byte_budget)
        begin
            build_blob();
            break_blob();
            queue_blob();
            queued += blob.size();
        end
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (byte_queue.size() != 0 || in_valid || expected_tags.size() != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_max_bytes(input logic [14:0] value);
        logic [31:0] readback;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_MAX_BLOB_BYTES;
        pwdata  <= {17'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        max_bytes = value;
        @(posedge clk);
        psel <= 1'b1;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== {17'd0, value})
            flag_mismatch($sformatf("max_blob_bytes read back %0h, expected %0h",
                                    readback, value));
    endtask

    initial
    begin
        clear_parse();
        wait (rst_n === 1'b1);
        @(posedge clk);

        // Directed blobs at the reset limit.
        send_hex({"01 00 05 00 00 01 00 00 00 00 00 01 41 03 01 00 00 03 00 ",
                  "00 00 02 80 00 00 00 00 00 00 00 00 01 4B 01 00 00 00 02 61 62"});
        send_hex("01 00 00");
        send_hex("FF 00 00");
        send_hex("01 00 01 00 00 04 00");
        send_hex("01 00 01 00 00 03 02");
        send_hex("01 00 01 00");
        send_hex("01 00 00 AA");
        send_hex("01 00 01 00 00 02 7F FF FF FF FF FF FF FF");
        send_hex("01");
        wait_idle();

        // A blob exactly at the limit passes, one byte over fails.
        build_blob();
        write_max_bytes(15'(blob.size()));
        queue_blob();
        wait_idle();
        write_max_bytes(15'(blob.size() - 1));
        queue_blob();
        wait_idle();

        // A zero limit rejects even the shortest blob.
        write_max_bytes(15'd0);
        send_hex("01 00 00");
        send_hex("01");
        wait_idle();

        write_max_bytes(15'd1);
        random_blobs(20);
        wait_idle();

        write_max_bytes(15'($urandom_range(10, 40)));
        random_blobs(50);
        wait_idle();

        // The result side holds off for a long stretch while bytes keep coming.
        write_max_bytes(MAX_BYTES_RESET);
        hold_armed = 1'b1;
        random_blobs(100);
        wait_idle();

        quiet = 1'b1;
        write_max_bytes(15'h7FFF);
        random_blobs(40);
        wait_idle();
        quiet = 1'b0;

        write_max_bytes(15'($urandom_range(100, 32767)));
        random_blobs(40);
        wait_idle();

        if (tag_errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
